>>> hdl/afcr_pkg.sv
// ----------------------------------------------------------------------------
// API frame command receiver package
// Shared constants, types and result codes of the frame command receiver.
// ----------------------------------------------------------------------------
package afcr_pkg;

  // Number of command slots that the consumer can hold at once.
  localparam int unsigned SLOTS = 4;
  // Largest frame, in bytes, that the receiver takes without aborting.
  localparam int unsigned FRAME_BYTES = 128;

  // Width of the free slot count, wide enough to hold SLOTS itself.
  localparam int unsigned SlotW = $clog2(SLOTS + 1);

  // Reset value of the start delimiter register.
  localparam logic [7:0] StartByteReset = 8'h7E;

  // Frame positions and sizes.
  localparam logic [7:0] PosHunt      = 8'd0;
  localparam logic [7:0] PosLenHi     = 8'd1;
  localparam logic [7:0] PosLenLo     = 8'd2;
  localparam logic [7:0] PosFirstBody = 8'd3;
  localparam logic [7:0] TypePos      = 8'd15;
  localparam logic [7:0] DataPos      = 8'd16;
  localparam logic [7:0] MinDataLen   = 8'd14;
  localparam logic [8:0] ChecksumOfs  = 9'd3;
  localparam logic [9:0] FrameOvh     = 10'd4;
  localparam logic [9:0] FrameMax     = 10'(FRAME_BYTES);

  // Input word kinds.
  localparam logic KindByte    = 1'b0;
  localparam logic KindRelease = 1'b1;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_ACCEPT   = 2'd1,
    EV_REJECT   = 2'd2,
    EV_OVERSIZE = 2'd3
  } afcr_event_e;

  // Slot counter control from the frame logic.
  typedef struct packed {
    logic release_slot;
    logic take_slot;
  } afcr_slot_ctl_t;

endpackage

>>> hdl/afcr_in_if.sv
// ----------------------------------------------------------------------------
// Input word channel
// Carries received bytes and slot release words into the receiver.
// ----------------------------------------------------------------------------
interface afcr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

>>> hdl/afcr_out_if.sv
// ----------------------------------------------------------------------------
// Result word channel
// Carries command data bytes and frame closing events out of the receiver.
// ----------------------------------------------------------------------------
interface afcr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] data_byte;
  logic [7:0] msg_type;
  logic       last;

  modport source (output valid, output event_res, output data_byte, output msg_type,
                  output last, input ready);
  modport sink (input valid, input event_res, input data_byte, input msg_type,
                input last, output ready);
endinterface

>>> hdl/afcr_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the start delimiter value into the receiver.
// ----------------------------------------------------------------------------
interface afcr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/afcr_slot_counter.sv
// ----------------------------------------------------------------------------
// Command slot counter
// Counts free command slots; a release frees one, an accepted command takes one.
// ----------------------------------------------------------------------------
module afcr_slot_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  afcr_pkg::afcr_slot_ctl_t     ctl_i,
  output logic [afcr_pkg::SlotW-1:0]   free_o,
  output logic                         has_free_o
);

  logic [afcr_pkg::SlotW-1:0] free_q, free_d;

  // Release saturates at the full count; take stops at zero.
  always_comb begin
    free_d = free_q;
    if (ctl_i.release_slot && (free_q < afcr_pkg::SlotW'(afcr_pkg::SLOTS))) begin
      free_d = free_q + 1'b1;
    end else if (ctl_i.take_slot && (free_q != '0)) begin
      free_d = free_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= afcr_pkg::SlotW'(afcr_pkg::SLOTS);
    end else begin
      free_q <= free_d;
    end
  end

  assign free_o     = free_q;
  assign has_free_o = (free_q != '0);

endmodule

>>> hdl/api_frame_command_receiver_top.sv
// ----------------------------------------------------------------------------
// API frame command receiver
// Hunts for API frames in a received byte stream and streams command data.
// ----------------------------------------------------------------------------
// Each input word that is taken updates the frame position, length, type
// and slot count and, when it causes a result, loads the single output
// register, so a word can be accepted every cycle while the output side keeps
// up. The input stalls only while that output register holds a word that the
// sink has not taken. A frame opens with the start delimiter (cfg register,
// reset 0x7E), a zero length high byte and a length byte L; it closes on its
// checksum byte, L + 3 bytes after the start, with an accept or reject event
// carrying the type from frame byte 15. Bytes 16 up to the one before the
// checksum stream out as data unless the first of them is zero. A length
// giving more than FRAME_BYTES in all aborts at once with an oversize event.
// New frames are ignored while no command slot is free; the checksum is not
// checked.
module api_frame_command_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  afcr_in_if.sink     in_i,
  afcr_out_if.source  out_o,
  afcr_cfg_if.sink    cfg_i
);

  logic [7:0] start_q;
  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic       rej_q, rej_d;

  logic                         accept;
  logic                         res_valid;
  afcr_pkg::afcr_event_e        res_event;
  logic [7:0]                   res_data;
  logic [7:0]                   res_type;
  logic                         res_last;
  afcr_pkg::afcr_slot_ctl_t     slot_ctl;
  logic [afcr_pkg::SlotW-1:0]   free_slots;
  logic                         has_free;
  logic                         rej_next;

  logic                         out_valid_q;
  afcr_pkg::afcr_event_e        out_event_q;
  logic [7:0]                   out_data_q;
  logic [7:0]                   out_type_q;
  logic                         out_last_q;

  // Configuration: the start delimiter register, always writable.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= afcr_pkg::StartByteReset;
    end else if (cfg_i.valid) begin
      start_q <= cfg_i.data;
    end
  end

  // A word is taken whenever the output register is free or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Frame parser: next state and the result of the current word.
  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    type_d    = type_q;
    rej_d     = rej_q;
    res_valid = 1'b0;
    res_event = afcr_pkg::EV_DATA;
    res_data  = '0;
    res_type  = '0;
    res_last  = 1'b0;
    slot_ctl  = '0;
    rej_next  = rej_q;

    if (in_i.kind == afcr_pkg::KindRelease) begin
      slot_ctl.release_slot = 1'b1;
    end else if (pos_q == afcr_pkg::PosHunt) begin
      if (has_free && (in_i.rx_byte == start_q)) begin
        pos_d  = afcr_pkg::PosLenHi;
        len_d  = '0;
        type_d = '0;
        rej_d  = 1'b0;
      end
    end else if (pos_q == afcr_pkg::PosLenHi) begin
      pos_d = (in_i.rx_byte == 8'd0) ? afcr_pkg::PosLenLo : afcr_pkg::PosHunt;
    end else if (pos_q == afcr_pkg::PosLenLo) begin
      len_d = in_i.rx_byte;
      if (({2'b00, in_i.rx_byte} + afcr_pkg::FrameOvh) > afcr_pkg::FrameMax) begin
        pos_d     = afcr_pkg::PosHunt;
        res_valid = 1'b1;
        res_event = afcr_pkg::EV_OVERSIZE;
        res_last  = 1'b1;
      end else begin
        pos_d = afcr_pkg::PosFirstBody;
      end
    end else if ({1'b0, pos_q} >= ({1'b0, len_q} + afcr_pkg::ChecksumOfs)) begin
      // Checksum byte closes the frame.
      pos_d     = afcr_pkg::PosHunt;
      res_valid = 1'b1;
      res_type  = type_q;
      res_last  = 1'b1;
      if (rej_q || (len_q < afcr_pkg::MinDataLen)) begin
        res_event = afcr_pkg::EV_REJECT;
      end else begin
        res_event         = afcr_pkg::EV_ACCEPT;
        slot_ctl.take_slot = 1'b1;
      end
    end else begin
      pos_d = pos_q + 8'd1;
      if (pos_q == afcr_pkg::TypePos) begin
        type_d = in_i.rx_byte;
      end else if (pos_q >= afcr_pkg::DataPos) begin
        rej_next = rej_q || ((pos_q == afcr_pkg::DataPos) && (in_i.rx_byte == 8'd0));
        rej_d    = rej_next;
        if (!rej_next) begin
          res_valid = 1'b1;
          res_event = afcr_pkg::EV_DATA;
          res_data  = in_i.rx_byte;
          res_type  = type_q;
        end
      end
    end

    // Nothing changes unless the word is actually taken.
    if (!accept) begin
      pos_d     = pos_q;
      len_d     = len_q;
      type_d    = type_q;
      rej_d     = rej_q;
      res_valid = 1'b0;
      slot_ctl  = '0;
    end
  end

  afcr_slot_counter u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (slot_ctl),
    .free_o     (free_slots),
    .has_free_o (has_free)
  );

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= afcr_pkg::PosHunt;
      len_q  <= '0;
      type_q <= '0;
      rej_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      type_q <= type_d;
      rej_q  <= rej_d;
    end
  end

  // Output register: loads a new result, clears once the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_event_q <= res_event;
      out_data_q  <= res_data;
      out_type_q  <= res_type;
      out_last_q  <= res_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_event_q;
  assign out_o.data_byte = out_data_q;
  assign out_o.msg_type  = out_type_q;
  assign out_o.last      = out_last_q;

  // The free slot count never goes beyond the number of slots.
  a_slots_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_slots <= afcr_pkg::SlotW'(afcr_pkg::SLOTS))
    else $error("free slot count above SLOTS");

  // A stalled result blocks any new word.
  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !accept)
    else $error("word accepted while result stalled");

  // Only data words are not the last word of a frame.
  a_last_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_event_q != afcr_pkg::EV_DATA)))
    else $error("last flag inconsistent with event");

  // An accepted command consumes one slot in the next cycle.
  a_take_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res_event == afcr_pkg::EV_ACCEPT) && !slot_ctl.release_slot)
      |=> (free_slots == ($past(free_slots) - 1'b1)))
    else $error("accepted command did not take a slot");

endmodule
